@@ sv/lgs_pkg.sv @@
package lgs_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int DIM_W     = 7;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int CELLS     = MAX_ROWS * MAX_COLS;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W     = 4;

    typedef enum logic [1:0] {
        CELL_BLANK = 2'd0,
        CELL_LIVE  = 2'd1,
        CELL_SAND  = 2'd2,
        CELL_SOLID = 2'd3
    } cell_t;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_GEN   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } cfg_idx_t;

    localparam logic [2:0] READ_NONE    = 3'd0;
    localparam logic [2:0] READ_INVALID = 3'd4;

    typedef struct packed {
        logic op_accept;
        logic clr_step;
        logic gen_start;
        logic gen_issue;
        logic gen_next_row;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic col_last;
        logic row_last;
    } sts_t;

endpackage

@@ sv/lgs_dp.sv @@
module lgs_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lgs_pkg::cmd_t                       cmd,
    output lgs_pkg::sts_t                       sts,
    input  lgs_pkg::mode_t                      mode,
    input  logic [lgs_pkg::ROW_W-1:0]           row,
    input  logic [lgs_pkg::COL_W-1:0]           col,
    input  logic [1:0]                          wr_type,
    input  logic                                cfg_valid,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lgs_pkg::DIM_W-1:0]           cfg_data,
    output logic [2:0]                          read_type
);

    function automatic logic [lgs_pkg::DIM_W-1:0] clamp_dim
    (
        input logic [lgs_pkg::DIM_W-1:0] v,
        input logic [lgs_pkg::DIM_W-1:0] maxv
    );
        logic [lgs_pkg::DIM_W-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = lgs_pkg::DIM_W'(1);
            end
            else if (v > maxv)
            begin
                r = maxv;
            end
            return r;
        end
    endfunction

    logic [lgs_pkg::DIM_W-1:0]  rows_reg;
    logic [lgs_pkg::DIM_W-1:0]  cols_reg;
    logic [lgs_pkg::ADDR_W-1:0] clr_cnt_reg;
    logic [lgs_pkg::ROW_W-1:0]  gen_row_reg;
    logic [lgs_pkg::DIM_W-1:0]  rd_col_reg;
    logic                       s1_valid_reg;
    logic [lgs_pkg::DIM_W-1:0]  s1_col_reg;
    logic [2:0]                 left_live_reg;
    logic [2:0]                 ctr_live_reg;
    lgs_pkg::cell_t             ctr_type_reg;
    logic                       op_read_reg;
    logic                       op_inside_reg;
    logic [1:0]                 q_a_reg;
    logic [1:0]                 q_b_reg;
    logic [1:0]                 q_buf_reg;
    logic [2:0]                 read_type_reg;

    logic [1:0] store_mem [lgs_pkg::CELLS];
    logic [1:0] rowbuf_mem [lgs_pkg::MAX_COLS];

    logic                       inside_in;
    logic [lgs_pkg::ROW_W-1:0]  next_row;
    logic [lgs_pkg::ADDR_W-1:0] a_addr;
    logic                       a_ren;
    logic [lgs_pkg::ADDR_W-1:0] b_addr;
    logic                       st_we;
    logic [lgs_pkg::ADDR_W-1:0] st_waddr;
    logic [1:0]                 st_wdata;
    logic                       col_ok;
    logic                       buf_we;
    logic [lgs_pkg::DIM_W-1:0]  wr_col;
    logic [2:0]                 right_live;
    logic [lgs_pkg::CNT_W-1:0]  nbr_cnt;
    lgs_pkg::cell_t             new_type;
    logic                       row_last;

    // config registers, stored already clamped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= lgs_pkg::DIM_W'(lgs_pkg::MAX_ROWS);
            cols_reg <= lgs_pkg::DIM_W'(lgs_pkg::MAX_COLS);
        end
        else if (cfg_valid)
        begin
            unique case (lgs_pkg::cfg_idx_t'(cfg_index))
                lgs_pkg::CFG_ROWS:
                begin
                    rows_reg <= clamp_dim(cfg_data, lgs_pkg::DIM_W'(lgs_pkg::MAX_ROWS));
                end
                lgs_pkg::CFG_COLS:
                begin
                    cols_reg <= clamp_dim(cfg_data, lgs_pkg::DIM_W'(lgs_pkg::MAX_COLS));
                end
                default:
                begin
                end
            endcase
        end
    end

    assign inside_in = ({1'b0, row} < rows_reg) && ({1'b0, col} < cols_reg);
    assign next_row  = gen_row_reg + lgs_pkg::ROW_W'(1);
    assign row_last  = (lgs_pkg::DIM_W'({1'b0, gen_row_reg}) + lgs_pkg::DIM_W'(1)) >= rows_reg;

    assign sts.clr_last = &clr_cnt_reg;
    assign sts.col_last = rd_col_reg == cols_reg;
    assign sts.row_last = row_last;

    // sweep counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            gen_row_reg  <= '0;
            rd_col_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + lgs_pkg::ADDR_W'(1);
            end
            if (cmd.gen_start)
            begin
                gen_row_reg <= '0;
                rd_col_reg  <= '0;
            end
            else if (cmd.gen_next_row)
            begin
                gen_row_reg <= next_row;
                rd_col_reg  <= '0;
            end
            else if (cmd.gen_issue)
            begin
                rd_col_reg <= rd_col_reg + lgs_pkg::DIM_W'(1);
            end
            s1_valid_reg <= cmd.gen_issue;
        end
    end

    // memory port selection
    always_comb
    begin
        if (cmd.op_accept)
        begin
            a_addr = {row, col};
        end
        else
        begin
            a_addr = {gen_row_reg, rd_col_reg[lgs_pkg::COL_W-1:0]};
        end
        a_ren  = (cmd.op_accept && (mode == lgs_pkg::MODE_READ)) || cmd.gen_issue;
        b_addr = {next_row, rd_col_reg[lgs_pkg::COL_W-1:0]};
    end

    // right column of the 3x3 window, cells past the edge count as dead
    assign col_ok        = s1_col_reg < cols_reg;
    assign right_live[0] = col_ok && (gen_row_reg != '0) &&
                           (lgs_pkg::cell_t'(q_buf_reg) == lgs_pkg::CELL_LIVE);
    assign right_live[1] = col_ok && (lgs_pkg::cell_t'(q_a_reg) == lgs_pkg::CELL_LIVE);
    assign right_live[2] = col_ok && !row_last &&
                           (lgs_pkg::cell_t'(q_b_reg) == lgs_pkg::CELL_LIVE);

    assign nbr_cnt = lgs_pkg::CNT_W'(left_live_reg[0]) + lgs_pkg::CNT_W'(left_live_reg[1])
                   + lgs_pkg::CNT_W'(left_live_reg[2]) + lgs_pkg::CNT_W'(ctr_live_reg[0])
                   + lgs_pkg::CNT_W'(ctr_live_reg[2]) + lgs_pkg::CNT_W'(right_live[0])
                   + lgs_pkg::CNT_W'(right_live[1]) + lgs_pkg::CNT_W'(right_live[2]);

    always_comb
    begin
        case (ctr_type_reg)
            lgs_pkg::CELL_LIVE:
            begin
                new_type = ((nbr_cnt == lgs_pkg::CNT_W'(2)) || (nbr_cnt == lgs_pkg::CNT_W'(3)))
                         ? lgs_pkg::CELL_LIVE : lgs_pkg::CELL_BLANK;
            end
            lgs_pkg::CELL_BLANK:
            begin
                new_type = (nbr_cnt == lgs_pkg::CNT_W'(3))
                         ? lgs_pkg::CELL_LIVE : lgs_pkg::CELL_BLANK;
            end
            default:
            begin
                new_type = ctr_type_reg;
            end
        endcase
    end

    assign wr_col = s1_col_reg - lgs_pkg::DIM_W'(1);
    assign buf_we = s1_valid_reg && col_ok;

    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = {gen_row_reg, wr_col[lgs_pkg::COL_W-1:0]};
        st_wdata = new_type;
        if (cmd.op_accept)
        begin
            st_we    = (mode == lgs_pkg::MODE_WRITE) && inside_in;
            st_waddr = {row, col};
            st_wdata = wr_type;
        end
        else if (cmd.clr_step)
        begin
            st_we    = 1'b1;
            st_waddr = clr_cnt_reg;
            st_wdata = lgs_pkg::CELL_BLANK;
        end
        else if (s1_valid_reg && (s1_col_reg != '0))
        begin
            st_we = 1'b1;
        end
    end

    // cell store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_waddr] <= st_wdata;
        end
        if (a_ren)
        begin
            q_a_reg <= store_mem[a_addr];
        end
        if (cmd.gen_issue)
        begin
            q_b_reg <= store_mem[b_addr];
        end
    end

    // old values of the row above
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            rowbuf_mem[s1_col_reg[lgs_pkg::COL_W-1:0]] <= q_a_reg;
        end
        if (cmd.gen_issue)
        begin
            q_buf_reg <= rowbuf_mem[rd_col_reg[lgs_pkg::COL_W-1:0]];
        end
    end

    // window shift and op/result registers
    always_ff @(posedge clk)
    begin
        if (cmd.gen_issue)
        begin
            s1_col_reg <= rd_col_reg;
        end
        if (s1_valid_reg)
        begin
            left_live_reg <= (s1_col_reg == '0) ? 3'b000 : ctr_live_reg;
            ctr_live_reg  <= right_live;
            ctr_type_reg  <= lgs_pkg::cell_t'(q_a_reg);
        end
        if (cmd.op_accept)
        begin
            op_read_reg   <= mode == lgs_pkg::MODE_READ;
            op_inside_reg <= inside_in;
        end
        if (cmd.out_load)
        begin
            read_type_reg <= !op_read_reg ? lgs_pkg::READ_NONE
                           : (op_inside_reg ? {1'b0, q_a_reg} : lgs_pkg::READ_INVALID);
        end
    end

    assign read_type = read_type_reg;

`ifndef SYNTHESIS
    a_s1_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && $past(s1_valid_reg)) |->
        (s1_col_reg == lgs_pkg::DIM_W'($past(s1_col_reg) + lgs_pkg::DIM_W'(1))))
        else $error("window column did not advance by one");

    a_clr_gen_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clr_step && (cmd.gen_issue || s1_valid_reg)))
        else $error("clearing pass overlaps generation sweep");
`endif

endmodule

@@ sv/lgs_ctrl.sv @@
module lgs_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  lgs_pkg::mode_t  mode,
    input  logic            out_ready,
    input  lgs_pkg::sts_t   sts,
    output logic            in_ready,
    output logic            out_valid,
    output lgs_pkg::cmd_t   cmd
);

    typedef enum logic [5:0] {
        S_INIT      = 6'b000001,
        S_IDLE      = 6'b000010,
        S_CLEAR     = 6'b000100,
        S_GEN_ROW   = 6'b001000,
        S_GEN_DRAIN = 6'b010000,
        S_RESP      = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op_accept = 1'b1;
                    unique case (mode) inside
                        lgs_pkg::MODE_WRITE, lgs_pkg::MODE_READ:
                        begin
                            state_next = S_RESP;
                        end
                        lgs_pkg::MODE_CLEAR:
                        begin
                            state_next = S_CLEAR;
                        end
                        lgs_pkg::MODE_GEN:
                        begin
                            cmd.gen_start = 1'b1;
                            state_next    = S_GEN_ROW;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_GEN_ROW:
            begin
                cmd.gen_issue = 1'b1;
                if (sts.col_last)
                begin
                    state_next = S_GEN_DRAIN;
                end
            end
            S_GEN_DRAIN:
            begin
                if (sts.row_last)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.gen_next_row = 1'b1;
                    state_next       = S_GEN_ROW;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_gen_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (mode == lgs_pkg::MODE_GEN)) |=> (state_reg == S_GEN_ROW))
        else $error("generation beat did not start a row sweep");

    a_drain_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GEN_DRAIN) |=> ((state_reg == S_GEN_ROW) || (state_reg == S_RESP)))
        else $error("bad exit from row drain");
`endif

endmodule

@@ sv/life_generation_step.sv @@
// write and read: result loaded in S_RESP once the output is free; one item at a time
// clear: all 4096 store entries blanked, one store entry written per cycle
// generation: one cell per cycle through the store read ports while a row is swept,
//   then the drain state S_GEN_DRAIN before the next row
// reset: clearing pass of all 4096 cell store entries with in_ready low; config writes
//   are taken throughout, rows and cols reset to 64
module life_generation_step
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          mode,
    input  logic [lgs_pkg::ROW_W-1:0]           row,
    input  logic [lgs_pkg::COL_W-1:0]           col,
    input  logic [1:0]                          wr_type,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          read_type,
    output logic                                done_res,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lgs_pkg::DIM_W-1:0]           cfg_data
);

    lgs_pkg::cmd_t  cmd;
    lgs_pkg::sts_t  sts;
    lgs_pkg::mode_t mode_in;

    assign mode_in   = lgs_pkg::mode_t'(mode);
    assign cfg_ready = 1'b1;
    assign done_res  = 1'b1;

    lgs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .mode      (mode_in),
        .out_ready (out_ready),
        .sts       (sts),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    lgs_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .mode      (mode_in),
        .row       (row),
        .col       (col),
        .wr_type   (wr_type),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .read_type (read_type)
    );

endmodule
